### hw/rtl/lcc_pkg.sv
// Shared types for the level-crossing controller.
// State encoding and the controller context record; no dependencies.
`default_nettype none

package lcc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_EAST        = 3'd1,
    ST_WEST        = 3'd2,
    ST_BOTH        = 3'd3,
    ST_GATE_EAST   = 3'd4,
    ST_GATE_WEST   = 3'd5,
    ST_GATE_BOTH   = 3'd6,
    ST_CLEARING    = 3'd7
  } xing_state_t;

  localparam int unsigned SensorW = 5;

  localparam int unsigned BitEastIn  = 0;
  localparam int unsigned BitWestIn  = 1;
  localparam int unsigned BitEastOut = 2;
  localparam int unsigned BitWestOut = 3;
  localparam int unsigned BitGate    = 4;

  typedef struct packed {
    xing_state_t present;
    xing_state_t ret;
    logic        pending;
  } ctx_t;

endpackage

`default_nettype wire

### hw/rtl/lcc_next.sv
// Next-state logic of the level-crossing controller for one sensor transaction.
// Depends on lcc_pkg for the state encoding and context record.
`default_nettype none

module lcc_next (
  input  wire logic                        sensor_update,
  input  wire logic [lcc_pkg::SensorW-1:0] sensor_bits,
  input  wire logic                        priority_request,
  input  wire lcc_pkg::ctx_t               cur,
  output lcc_pkg::ctx_t                    nxt
);
  import lcc_pkg::*;

  logic ein, win, eout, wout, gate, pri;

  assign ein  = sensor_bits[BitEastIn];
  assign win  = sensor_bits[BitWestIn];
  assign eout = sensor_bits[BitEastOut];
  assign wout = sensor_bits[BitWestOut];
  assign gate = sensor_bits[BitGate];
  assign pri  = priority_request;

  always_comb begin
    nxt = cur;
    if (sensor_update) begin
      case (cur.present)
        ST_IDLE: begin
          if (pri) begin
            nxt.ret     = ST_IDLE;
            nxt.pending = 1'b1;
          end else if (cur.pending) begin
            nxt.present = cur.ret;
            nxt.pending = 1'b0;
          end else if (ein && win) begin
            nxt.present = ST_BOTH;
          end else if (ein) begin
            nxt.present = ST_EAST;
          end else if (win) begin
            nxt.present = ST_WEST;
          end
        end
        ST_EAST: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_EAST, pending: 1'b1};
          end else if (win) begin
            nxt.present = ST_BOTH;
          end else if (gate) begin
            nxt.present = ST_GATE_EAST;
          end
        end
        ST_WEST: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_WEST, pending: 1'b1};
          end else if (ein) begin
            nxt.present = ST_BOTH;
          end else if (gate) begin
            nxt.present = ST_GATE_WEST;
          end
        end
        ST_BOTH: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_BOTH, pending: 1'b1};
          end else if (gate) begin
            nxt.present = ST_GATE_BOTH;
          end
        end
        ST_GATE_EAST: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_EAST, pending: 1'b1};
          end else if (win) begin
            nxt.present = ST_GATE_BOTH;
          end else if (eout) begin
            nxt.present = ST_CLEARING;
          end
        end
        ST_GATE_WEST: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_WEST, pending: 1'b1};
          end else if (ein) begin
            nxt.present = ST_GATE_BOTH;
          end else if (wout) begin
            nxt.present = ST_CLEARING;
          end
        end
        ST_GATE_BOTH: begin
          if (pri) begin
            nxt = '{present: ST_CLEARING, ret: ST_BOTH, pending: 1'b1};
          end else if (wout && eout) begin
            nxt.present = ST_CLEARING;
          end else if (wout) begin
            nxt.present = ST_GATE_EAST;
          end else if (eout) begin
            nxt.present = ST_GATE_WEST;
          end
        end
        ST_CLEARING: begin
          if (pri) begin
            if (!gate) nxt.present = ST_IDLE;
          end else if (ein && win) begin
            nxt.present = ST_GATE_BOTH;
          end else if (ein) begin
            nxt.present = ST_GATE_EAST;
          end else if (win) begin
            nxt.present = ST_GATE_WEST;
          end else if (!gate) begin
            nxt.present = ST_IDLE;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/level_crossing_controller_core.sv
// Level-crossing controller: input register, next-state logic, result register.
// An accepted transaction is held in the input register; its result is
// registered in the result register. Throughput: one transaction per cycle
// while out_stall does not hold the result; the context update is combinational.
// Reset: synchronous active-low rst_n empties both stages and returns the
// controller to idle with no override pending.
`default_nettype none

module level_crossing_controller_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_sensor_update,
  input  wire logic [lcc_pkg::SensorW-1:0] in_sensor_bits,
  input  wire logic                        in_priority_request,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [2:0]                       out_crossing_state,
  output logic                             out_override_pending
);
  import lcc_pkg::*;

  logic               s1_valid_r;
  logic               s1_update_r;
  logic [SensorW-1:0] s1_bits_r;
  logic               s1_pri_r;
  logic               s1_fire;
  logic               in_fire;

  ctx_t ctx_r;
  ctx_t ctx_nxt;

  logic       out_valid_r;
  logic [2:0] out_state_r;
  logic       out_pending_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  lcc_next u_next (
    .sensor_update    (s1_update_r),
    .sensor_bits      (s1_bits_r),
    .priority_request (s1_pri_r),
    .cur              (ctx_r),
    .nxt              (ctx_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctx_r       <= '{present: ST_IDLE, ret: ST_IDLE, pending: 1'b0};
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        ctx_r       <= ctx_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold payload while its stage is stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_update_r <= in_sensor_update;
      s1_bits_r   <= in_sensor_bits;
      s1_pri_r    <= in_priority_request;
    end
    if (s1_fire) begin
      out_state_r   <= ctx_nxt.present;
      out_pending_r <= ctx_nxt.pending;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_crossing_state   = out_state_r;
  assign out_override_pending = out_pending_r;

endmodule

`default_nettype wire

### test/lcc_scoreboard_pkg.sv
// Scoreboard for the level-crossing controller testbench: predicts the
// controller state and override flag for each transaction and checks results.
// Depends on lcc_pkg for the state encoding and sensor bit positions.
package lcc_scoreboard_pkg;

  import lcc_pkg::*;

  typedef struct {
    xing_state_t state;
    logic        pending;
  } xing_result_t;

  class crossing_scoreboard;
    xing_state_t  present;
    xing_state_t  saved;
    logic         pending;
    xing_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      present    = ST_IDLE;
      saved      = ST_IDLE;
      pending    = 1'b0;
      mismatches = 0;
    endfunction

    function void enter_clearing(xing_state_t back);
      pending = 1'b1;
      saved   = back;
      present = ST_CLEARING;
    endfunction

    function void note_transaction(logic upd, logic [SensorW-1:0] bits, logic pri);
      logic         ein;
      logic         win;
      logic         eout;
      logic         wout;
      logic         gate;
      xing_result_t item;
      ein  = bits[BitEastIn];
      win  = bits[BitWestIn];
      eout = bits[BitEastOut];
      wout = bits[BitWestOut];
      gate = bits[BitGate];
      if (upd) begin
        case (present)
          ST_IDLE: begin
            if (pri) begin
              saved   = ST_IDLE;
              pending = 1'b1;
            end
            if (pending) begin
              if (!pri) begin
                present = saved;
                pending = 1'b0;
              end
            end else if (ein && win) present = ST_BOTH;
            else if (ein) present = ST_EAST;
            else if (win) present = ST_WEST;
          end
          ST_EAST: begin
            if (pri) enter_clearing(ST_EAST);
            else if (win) present = ST_BOTH;
            else if (gate) present = ST_GATE_EAST;
          end
          ST_WEST: begin
            if (pri) enter_clearing(ST_WEST);
            else if (ein) present = ST_BOTH;
            else if (gate) present = ST_GATE_WEST;
          end
          ST_BOTH: begin
            if (pri) enter_clearing(ST_BOTH);
            else if (gate) present = ST_GATE_BOTH;
          end
          ST_GATE_EAST: begin
            if (pri) enter_clearing(ST_EAST);
            else if (win) present = ST_GATE_BOTH;
            else if (eout) present = ST_CLEARING;
          end
          ST_GATE_WEST: begin
            if (pri) enter_clearing(ST_WEST);
            else if (ein) present = ST_GATE_BOTH;
            else if (wout) present = ST_CLEARING;
          end
          ST_GATE_BOTH: begin
            if (pri) enter_clearing(ST_BOTH);
            else if (wout && eout) present = ST_CLEARING;
            else if (wout) present = ST_GATE_EAST;
            else if (eout) present = ST_GATE_WEST;
          end
          default: begin
            if (pri) begin
              if (!gate) present = ST_IDLE;
            end else if (ein && win) present = ST_GATE_BOTH;
            else if (ein) present = ST_GATE_EAST;
            else if (win) present = ST_GATE_WEST;
            else if (!gate) present = ST_IDLE;
          end
        endcase
      end
      item.state   = present;
      item.pending = pending;
      expected_q.push_back(item);
    endfunction

    function void check_result(logic [2:0] state, logic pend);
      xing_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: state %0d pending %0b", state, pend);
        return;
      end
      want = expected_q.pop_front();
      if (state !== want.state || pend !== want.pending) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected state %0d pending %0b, got state %0d pending %0b",
                   want.state, want.pending, state, pend);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

  endclass

endpackage

### test/level_crossing_controller_core_test.sv
// Top-level testbench for level_crossing_controller_core: directed override
// and gate sequences, then random sensor traffic under varying idle and stall.
// Depends on lcc_pkg and lcc_scoreboard_pkg.
module level_crossing_controller_core_test;

  import lcc_pkg::*;
  import lcc_scoreboard_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 220;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_sensor_update = 1'b0;
  logic [SensorW-1:0] in_sensor_bits = '0;
  logic               in_priority_request = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_crossing_state;
  logic               out_override_pending;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  crossing_scoreboard sb = new();

  level_crossing_controller_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sensor_update    (in_sensor_update),
    .in_sensor_bits      (in_sensor_bits),
    .in_priority_request (in_priority_request),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_crossing_state  (out_crossing_state),
    .out_override_pending(out_override_pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_crossing_state, out_override_pending);
  end

  task automatic send_transaction(input logic upd, input logic [SensorW-1:0] bits,
                                  input logic pri);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_sensor_update    <= upd;
    in_sensor_bits      <= bits;
    in_priority_request <= pri;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transaction(upd, bits, pri);
  endtask

  task automatic send_random_traffic(input int unsigned count);
    logic pri_hold;
    logic pri;
    pri_hold = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) pri_hold = ~pri_hold;
      pri = pri_hold;
      if ($urandom_range(19) == 0) pri = ~pri;
      send_transaction($urandom_range(99) < 85, SensorW'($urandom_range(31)), pri);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: gate sequences, override entry, hold, release and restore
    send_transaction(1'b0, 5'b11111, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b0);
    send_transaction(1'b1, 5'b00001, 1'b0);
    send_transaction(1'b1, 5'b10000, 1'b0);
    send_transaction(1'b1, 5'b00010, 1'b0);
    send_transaction(1'b1, 5'b01000, 1'b0);
    send_transaction(1'b1, 5'b00100, 1'b0);
    send_transaction(1'b1, 5'b00000, 1'b0);
    send_transaction(1'b1, 5'b00010, 1'b0);
    send_transaction(1'b1, 5'b00001, 1'b0);
    send_transaction(1'b1, 5'b10000, 1'b0);
    send_transaction(1'b1, 5'b01100, 1'b0);
    send_transaction(1'b1, 5'b10010, 1'b0);
    send_transaction(1'b1, 5'b10000, 1'b1);
    send_transaction(1'b1, 5'b10000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b0);
    send_transaction(1'b1, 5'b11111, 1'b0);
    send_transaction(1'b0, 5'b00000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b1);
    send_transaction(1'b1, 5'b10011, 1'b0);
    send_transaction(1'b1, 5'b01000, 1'b0);
    send_transaction(1'b1, 5'b10000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b1);
    send_transaction(1'b1, 5'b00000, 1'b0);

    send_random_traffic(PhaseItems);
    idle_pct = 46;
    send_random_traffic(PhaseItems);
    idle_pct  = 0;
    stall_pct = 46;
    send_random_traffic(PhaseItems);
    idle_pct  = 19;
    stall_pct = 19;
    send_random_traffic(PhaseItems);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
